// ===== rtl/core/torus_mesh_generator_unit_assert.svh =====
// Assertion macros for the torus mesh generator RTL
`ifndef TORUS_MESH_GENERATOR_UNIT_ASSERT_SVH
`define TORUS_MESH_GENERATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define TMG_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("torus mesh generator check failed");

// next-cycle implication
`define TMG_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("torus mesh generator check failed");

`endif

// ===== rtl/core/tmg_pkg.sv =====
`default_nettype none
package tmg_pkg;

   localparam int MAX_SIDES_DEF = 256;
   localparam int MAX_RINGS_DEF = 256;

   // register map
   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTER_RADIUS = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_RADIUS = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIDE_COUNT   = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RING_COUNT   = 4'd3;

   localparam logic [15:0] OUTER_RADIUS_RST = 16'd256;
   localparam logic [15:0] INNER_RADIUS_RST = 16'd64;
   localparam logic [8:0]  SIDE_COUNT_RST   = 9'd24;
   localparam logic [8:0]  RING_COUNT_RST   = 9'd48;

   localparam logic KIND_VERTEX = 1'b0;
   localparam logic KIND_INDEX  = 1'b1;

   // result slots of one grid position
   localparam logic [2:0] SLOT_VERTEX = 3'd0;
   localparam logic [2:0] SLOT_IDX_A0 = 3'd1;
   localparam logic [2:0] SLOT_IDX_B  = 3'd2;
   localparam logic [2:0] SLOT_IDX_C0 = 3'd3;
   localparam logic [2:0] SLOT_IDX_A1 = 3'd4;
   localparam logic [2:0] SLOT_IDX_C1 = 3'd5;
   localparam logic [2:0] SLOT_IDX_D  = 3'd6;

   // phase divider: 25-bit dividend, 17-bit quotient, 9-bit divisor
   localparam int DVD_W          = 25;
   localparam int QUO_W          = 17;
   localparam int REM_W          = 9;
   localparam int DIV_BITS_STAGE = 4;
   localparam int DIV_STAGES     = (QUO_W + DIV_BITS_STAGE - 1) / DIV_BITS_STAGE;

   localparam int SIN_LAT  = 7;
   localparam int GEOM_LAT = 3;
   localparam int PIPE_DEPTH = DIV_STAGES + SIN_LAT + GEOM_LAT;
   localparam int TEX_DEPTH  = SIN_LAT + GEOM_LAT;

   // odd polynomial for sin(pi/2 x), Q28
   localparam logic [28:0] SIN_C1 = 29'd421657428;
   localparam logic [28:0] SIN_C3 = 29'd173399667;
   localparam logic [28:0] SIN_C5 = 29'd21392326;
   localparam logic [28:0] SIN_C7 = 29'd1256748;
   localparam logic [28:0] SIN_C9 = 29'd43068;

   typedef struct packed {
      logic        valid;
      logic        faces;
      logic [16:0] idx_a;
      logic [16:0] idx_b;
      logic [16:0] idx_c;
      logic [16:0] idx_d;
   } ctl_type;

   typedef struct packed {
      logic signed [17:0] pos_x;
      logic signed [17:0] pos_y;
      logic signed [17:0] pos_z;
      logic signed [15:0] norm_x;
      logic signed [15:0] norm_y;
      logic signed [15:0] norm_z;
      logic [16:0]        tex_s;
      logic [15:0]        tex_t;
   } vtx_type;

   function automatic logic [28:0] horner_step(input logic [28:0] c,
                                               input logic [28:0] s,
                                               input logic [28:0] z);
      logic [57:0] prod;
      prod = s * z;
      return c - prod[56:28];
   endfunction

   function automatic logic signed [17:0] clamp_pos(input logic signed [19:0] v);
      logic signed [17:0] res;
      if (v > 20'sd131071) res = 18'sd131071;
      else if (v < -20'sd131072) res = -18'sd131072;
      else res = v[17:0];
      return res;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tmg_div.sv =====
`default_nettype none
module tmg_div import tmg_pkg::*; (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [REM_W-1:0] divisor,
   output logic      [QUO_W-1:0] quotient
);

   // restoring division, DIV_BITS_STAGE quotient bits per stage
   logic [REM_W-1:0] rem_ff [DIV_STAGES];
   logic [QUO_W-1:0] low_ff [DIV_STAGES];
   logic [REM_W-1:0] den_ff [DIV_STAGES];

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
      logic [REM_W-1:0] rem_src;
      logic [QUO_W-1:0] low_src;
      logic [REM_W-1:0] den_src;
      logic [REM_W-1:0] rem_in;
      logic [QUO_W-1:0] low_in;
      logic [REM_W-1:0] den_in;
      logic [REM_W:0]   trial;

      if (g == 0) begin : g_head
         assign rem_src = REM_W'(dividend[DVD_W-1:QUO_W]);
         assign low_src = dividend[QUO_W-1:0];
         assign den_src = divisor;
      end else begin : g_next
         assign rem_src = rem_ff[g-1];
         assign low_src = low_ff[g-1];
         assign den_src = den_ff[g-1];
      end

      always_comb begin
         rem_in = rem_src;
         low_in = low_src;
         den_in = den_src;
         trial = '0;
         for (int j = 0; j < DIV_BITS_STAGE; j++) begin
            if (g * DIV_BITS_STAGE + j < QUO_W) begin
               trial  = {rem_in, low_in[QUO_W-1]};
               low_in = {low_in[QUO_W-2:0], 1'b0};
               if (trial >= {1'b0, den_in}) begin
                  trial     = trial - {1'b0, den_in};
                  low_in[0] = 1'b1;
               end
               rem_in = trial[REM_W-1:0];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g] <= rem_in;
            low_ff[g] <= low_in;
            den_ff[g] <= den_in;
         end
      end
   end

   assign quotient = low_ff[DIV_STAGES-1];

endmodule
`default_nettype wire

// ===== rtl/core/tmg_sin.sv =====
`default_nettype none
module tmg_sin import tmg_pkg::*; (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic [15:0]        phase,
   output logic signed [15:0]      value
);

   // stage 1 folds onto the first quadrant, stages 2-5 run Horner,
   // stage 6 multiplies by x, stage 7 rounds, caps and signs
   logic [14:0] x_in;
   logic [28:0] xsq;
   logic [14:0] x_ff   [1:5];
   logic [28:0] z_ff   [1:4];
   logic        neg_ff [1:6];
   logic [28:0] s_ff   [2:5];
   logic [43:0] prod_ff;
   logic [43:0] prod_in;
   logic [16:0] mag;
   logic [16:0] mag_cap;
   logic signed [15:0] value_ff;
   logic signed [15:0] value_in;

   always_comb begin
      if (phase[14]) x_in = 15'd16384 - {1'b0, phase[13:0]};
      else x_in = {1'b0, phase[13:0]};
   end
   assign xsq = 29'(x_in * x_in);

   assign prod_in = s_ff[5] * x_ff[5];

   always_comb begin
      mag      = 17'((prod_ff + 44'd134217728) >> 28);
      mag_cap  = (mag > 17'd16384) ? 17'd16384 : mag;
      value_in = neg_ff[6] ? -$signed(mag_cap[15:0]) : $signed(mag_cap[15:0]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[1]   <= x_in;
         z_ff[1]   <= xsq;
         neg_ff[1] <= phase[15];
         for (int k = 2; k <= 5; k++) x_ff[k] <= x_ff[k-1];
         for (int k = 2; k <= 6; k++) neg_ff[k] <= neg_ff[k-1];
         for (int k = 2; k <= 4; k++) z_ff[k] <= z_ff[k-1];
         s_ff[2]  <= horner_step(SIN_C7, SIN_C9, z_ff[1]);
         s_ff[3]  <= horner_step(SIN_C5, s_ff[2], z_ff[2]);
         s_ff[4]  <= horner_step(SIN_C3, s_ff[3], z_ff[3]);
         s_ff[5]  <= horner_step(SIN_C1, s_ff[4], z_ff[4]);
         prod_ff  <= prod_in;
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule
`default_nettype wire

// ===== rtl/core/tmg_geom.sv =====
`default_nettype none
module tmg_geom import tmg_pkg::*; (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic [15:0]        outer_radius,
   input  wire logic [15:0]        inner_radius,
   input  wire logic signed [15:0] cos_u,
   input  wire logic signed [15:0] sin_u,
   input  wire logic signed [15:0] cos_v,
   input  wire logic signed [15:0] sin_v,
   output logic signed [17:0]      pos_x,
   output logic signed [17:0]      pos_y,
   output logic signed [17:0]      pos_z,
   output logic signed [15:0]      norm_x,
   output logic signed [15:0]      norm_y,
   output logic signed [15:0]      norm_z
);

   // stage 1: tube radius term and normal products
   logic signed [31:0] r_in, r_ff;
   logic signed [31:0] pcc_in, pcc_ff, pcs_in, pcs_ff, pz_in, pz_ff;
   logic signed [15:0] cu_ff, su_ff, sv_ff;

   assign r_in   = $signed({2'b00, outer_radius, 14'b0})
                 + $signed({1'b0, inner_radius}) * cos_v;
   assign pcc_in = cos_v * cos_u;
   assign pcs_in = cos_v * sin_u;
   assign pz_in  = $signed({1'b0, inner_radius}) * sin_v;

   // stage 2: position products, z position and normal rounding, flip normals on negative r
   logic signed [47:0] px_in, px_ff, py_in, py_ff;
   logic signed [31:0] nx_sum, ny_sum, pz_sum;
   logic signed [15:0] nx_raw, ny_raw;
   logic signed [15:0] nx_in, ny_in, nz_in, nx_ff, ny_ff, nz_ff;
   logic signed [17:0] pzr_in, pzr_ff;

   assign px_in = r_ff * cu_ff;
   assign py_in = r_ff * su_ff;

   always_comb begin
      nx_sum = pcc_ff + 32'sd8192;
      ny_sum = pcs_ff + 32'sd8192;
      pz_sum = pz_ff + 32'sd8192;
      nx_raw = nx_sum[29:14];
      ny_raw = ny_sum[29:14];
      pzr_in = pz_sum[31:14];
      if (r_ff[31]) begin
         nx_in = -nx_raw;
         ny_in = -ny_raw;
         nz_in = -sv_ff;
      end else begin
         nx_in = nx_raw;
         ny_in = ny_raw;
         nz_in = sv_ff;
      end
   end

   // stage 3: round x and y positions to Q9.8 and saturate them
   logic signed [47:0] pxr_sum, pyr_sum;
   logic signed [17:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic signed [15:0] nx3_ff, ny3_ff, nz3_ff;

   assign pxr_sum = px_ff + 48'sd134217728;
   assign pyr_sum = py_ff + 48'sd134217728;

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff     <= r_in;
         pcc_ff   <= pcc_in;
         pcs_ff   <= pcs_in;
         pz_ff    <= pz_in;
         cu_ff    <= cos_u;
         su_ff    <= sin_u;
         sv_ff    <= sin_v;
         px_ff    <= px_in;
         py_ff    <= py_in;
         nx_ff    <= nx_in;
         ny_ff    <= ny_in;
         nz_ff    <= nz_in;
         pzr_ff   <= pzr_in;
         pos_x_ff <= clamp_pos(pxr_sum[47:28]);
         pos_y_ff <= clamp_pos(pyr_sum[47:28]);
         pos_z_ff <= pzr_ff;
         nx3_ff   <= nx_ff;
         ny3_ff   <= ny_ff;
         nz3_ff   <= nz_ff;
      end
   end

   assign pos_x  = pos_x_ff;
   assign pos_y  = pos_y_ff;
   assign pos_z  = pos_z_ff;
   assign norm_x = nx3_ff;
   assign norm_y = ny3_ff;
   assign norm_z = nz3_ff;

endmodule
`default_nettype wire

// ===== rtl/core/tmg_emit.sv =====
`default_nettype none
`include "torus_mesh_generator_unit_assert.svh"
module tmg_emit import tmg_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ctl_type            fin_ctl,
   input  wire vtx_type            fin_vtx,
   output logic                    take,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_result_kind,
   output logic signed [17:0]      rsp_pos_x,
   output logic signed [17:0]      rsp_pos_y,
   output logic signed [17:0]      rsp_pos_z,
   output logic signed [15:0]      rsp_norm_x,
   output logic signed [15:0]      rsp_norm_y,
   output logic signed [15:0]      rsp_norm_z,
   output logic [16:0]             rsp_tex_s,
   output logic [15:0]             rsp_tex_t,
   output logic [16:0]             rsp_vertex_index,
   output logic                    rsp_last
);

   logic       valid_ff, valid_in;
   logic [2:0] cnt_ff, cnt_in;
   ctl_type    ctl_ff;
   vtx_type    vtx_ff;
   logic       is_index;
   logic       at_end;
   logic       done;
   logic       fire;

   assign is_index = (cnt_ff != SLOT_VERTEX);
   assign at_end   = ctl_ff.faces ? (cnt_ff == SLOT_IDX_D) : (cnt_ff == SLOT_VERTEX);
   assign done     = valid_ff && rsp_ready && at_end;
   assign take     = fin_ctl.valid && (!valid_ff || done);
   assign fire     = valid_ff && rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      cnt_in   = cnt_ff;
      if (take) begin
         valid_in = 1'b1;
         cnt_in   = SLOT_VERTEX;
      end else if (done) begin
         valid_in = 1'b0;
      end else if (valid_ff && rsp_ready) begin
         cnt_in = cnt_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff   <= SLOT_VERTEX;
      end else begin
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         ctl_ff <= fin_ctl;
         vtx_ff <= fin_vtx;
      end
   end

   always_comb begin
      case (cnt_ff)
         SLOT_IDX_A0, SLOT_IDX_A1: rsp_vertex_index = ctl_ff.idx_a;
         SLOT_IDX_B:               rsp_vertex_index = ctl_ff.idx_b;
         SLOT_IDX_C0, SLOT_IDX_C1: rsp_vertex_index = ctl_ff.idx_c;
         SLOT_IDX_D:               rsp_vertex_index = ctl_ff.idx_d;
         default:                  rsp_vertex_index = '0;
      endcase
   end

   assign rsp_valid       = valid_ff;
   assign rsp_result_kind = is_index ? KIND_INDEX : KIND_VERTEX;
   assign rsp_pos_x       = is_index ? '0 : vtx_ff.pos_x;
   assign rsp_pos_y       = is_index ? '0 : vtx_ff.pos_y;
   assign rsp_pos_z       = is_index ? '0 : vtx_ff.pos_z;
   assign rsp_norm_x      = is_index ? '0 : vtx_ff.norm_x;
   assign rsp_norm_y      = is_index ? '0 : vtx_ff.norm_y;
   assign rsp_norm_z      = is_index ? '0 : vtx_ff.norm_z;
   assign rsp_tex_s       = is_index ? '0 : vtx_ff.tex_s;
   assign rsp_tex_t       = is_index ? '0 : vtx_ff.tex_t;
   assign rsp_last        = at_end;

   `TMG_ASSERT_IMP(a_slot_range, valid_ff, cnt_ff <= SLOT_IDX_D)
   `TMG_ASSERT_IMP(a_flat_last, valid_ff && !ctl_ff.faces && !is_index, rsp_last)
   `TMG_ASSERT_IMP(a_no_overwrite, take, !valid_ff || (rsp_ready && rsp_last))
   `TMG_ASSERT_NXT(a_vertex_then_index, fire && !rsp_last && !is_index, cnt_ff == SLOT_IDX_A0)

endmodule
`default_nettype wire

// ===== rtl/core/torus_mesh_generator_unit.sv =====
// An accepted transaction passes 5 divider, 7 sine and 3 geometry stages and then
// the output register before its vertex result appears.
// Throughput: one transaction per cycle until the output backs the pipeline up;
// a position with faces holds the output for seven results, one without faces for a single result.
// Reset (synchronous, active high) drops all in-flight transactions and
// restores the register defaults.
`default_nettype none
module torus_mesh_generator_unit import tmg_pkg::*; #(
   parameter int MAX_SIDES = MAX_SIDES_DEF,
   parameter int MAX_RINGS = MAX_RINGS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [15:0]          csr_wdata,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [8:0]           req_ring_pos,
   input  wire logic [7:0]           req_side_pos,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_result_kind,
   output logic signed [17:0]        rsp_pos_x,
   output logic signed [17:0]        rsp_pos_y,
   output logic signed [17:0]        rsp_pos_z,
   output logic signed [15:0]        rsp_norm_x,
   output logic signed [15:0]        rsp_norm_y,
   output logic signed [15:0]        rsp_norm_z,
   output logic [16:0]               rsp_tex_s,
   output logic [15:0]               rsp_tex_t,
   output logic [16:0]               rsp_vertex_index,
   output logic                      rsp_last
);

   logic [15:0] outer_radius_ff, inner_radius_ff;
   logic [8:0]  side_count_ff, ring_count_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         outer_radius_ff <= OUTER_RADIUS_RST;
         inner_radius_ff <= INNER_RADIUS_RST;
         side_count_ff   <= SIDE_COUNT_RST;
         ring_count_ff   <= RING_COUNT_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_OUTER_RADIUS: outer_radius_ff <= csr_wdata;
            CSR_INNER_RADIUS: inner_radius_ff <= csr_wdata;
            CSR_SIDE_COUNT:   side_count_ff   <= csr_wdata[8:0];
            CSR_RING_COUNT:   ring_count_ff   <= csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   // pipeline advances as a whole; it stalls only when the last stage is full
   logic en;
   logic take;
   ctl_type ctl_ff [PIPE_DEPTH];
   ctl_type ctl_in;

   assign en        = !ctl_ff[PIPE_DEPTH-1].valid || take;
   assign req_ready = en;

   logic             in_range;
   logic [17:0]      here;
   logic [17:0]      next;
   logic [8:0]       nside;
   logic [DVD_W-1:0] num_u, num_v;

   always_comb begin
      in_range = (side_count_ff != 9'd0) && (ring_count_ff != 9'd0)
              && (int'(side_count_ff) <= MAX_SIDES) && (int'(ring_count_ff) <= MAX_RINGS)
              && (req_ring_pos <= ring_count_ff) && ({1'b0, req_side_pos} < side_count_ff);
      here   = req_ring_pos * side_count_ff;
      next   = here + {9'd0, side_count_ff};
      nside  = ({1'b0, req_side_pos} + 9'd1 == side_count_ff) ? 9'd0
             : {1'b0, req_side_pos} + 9'd1;
      ctl_in.valid = req_valid && in_range;
      ctl_in.faces = req_ring_pos < ring_count_ff;
      ctl_in.idx_a = 17'(here + {10'd0, req_side_pos});
      ctl_in.idx_b = 17'(next + {10'd0, req_side_pos});
      ctl_in.idx_c = 17'(next + {9'd0, nside});
      ctl_in.idx_d = 17'(here + {9'd0, nside});
      num_u = {req_ring_pos, 16'd0} + DVD_W'(ring_count_ff >> 1);
      num_v = {1'b0, req_side_pos, 16'd0} + DVD_W'(side_count_ff >> 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PIPE_DEPTH; k++) ctl_ff[k].valid <= 1'b0;
      end else if (en) begin
         ctl_ff[0] <= ctl_in;
         for (int k = 1; k < PIPE_DEPTH; k++) ctl_ff[k] <= ctl_ff[k-1];
      end
   end

   logic [QUO_W-1:0] phase_u, phase_v;

   tmg_div u_div_u (
      .clock    (clock),
      .en       (en),
      .dividend (num_u),
      .divisor  (ring_count_ff),
      .quotient (phase_u)
   );

   tmg_div u_div_v (
      .clock    (clock),
      .en       (en),
      .dividend (num_v),
      .divisor  (side_count_ff),
      .quotient (phase_v)
   );

   // texture coordinates ride alongside the sine and geometry stages
   logic [16:0] tex_s_ff [TEX_DEPTH];
   logic [15:0] tex_t_ff [TEX_DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         tex_s_ff[0] <= phase_u;
         tex_t_ff[0] <= phase_v[15:0];
         for (int k = 1; k < TEX_DEPTH; k++) begin
            tex_s_ff[k] <= tex_s_ff[k-1];
            tex_t_ff[k] <= tex_t_ff[k-1];
         end
      end
   end

   logic signed [15:0] cos_u, sin_u, cos_v, sin_v;

   tmg_sin u_cos_u (.clock(clock), .en(en), .phase(phase_u[15:0] + 16'd16384), .value(cos_u));
   tmg_sin u_sin_u (.clock(clock), .en(en), .phase(phase_u[15:0]),             .value(sin_u));
   tmg_sin u_cos_v (.clock(clock), .en(en), .phase(phase_v[15:0] + 16'd16384), .value(cos_v));
   tmg_sin u_sin_v (.clock(clock), .en(en), .phase(phase_v[15:0]),             .value(sin_v));

   vtx_type fin_vtx;

   tmg_geom u_geom (
      .clock        (clock),
      .en           (en),
      .outer_radius (outer_radius_ff),
      .inner_radius (inner_radius_ff),
      .cos_u        (cos_u),
      .sin_u        (sin_u),
      .cos_v        (cos_v),
      .sin_v        (sin_v),
      .pos_x        (fin_vtx.pos_x),
      .pos_y        (fin_vtx.pos_y),
      .pos_z        (fin_vtx.pos_z),
      .norm_x       (fin_vtx.norm_x),
      .norm_y       (fin_vtx.norm_y),
      .norm_z       (fin_vtx.norm_z)
   );

   assign fin_vtx.tex_s = tex_s_ff[TEX_DEPTH-1];
   assign fin_vtx.tex_t = tex_t_ff[TEX_DEPTH-1];

   tmg_emit u_emit (
      .clock            (clock),
      .reset            (reset),
      .fin_ctl          (ctl_ff[PIPE_DEPTH-1]),
      .fin_vtx          (fin_vtx),
      .take             (take),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_pos_z        (rsp_pos_z),
      .rsp_norm_x       (rsp_norm_x),
      .rsp_norm_y       (rsp_norm_y),
      .rsp_norm_z       (rsp_norm_z),
      .rsp_tex_s        (rsp_tex_s),
      .rsp_tex_t        (rsp_tex_t),
      .rsp_vertex_index (rsp_vertex_index),
      .rsp_last         (rsp_last)
   );

endmodule
`default_nettype wire
